// ===== design/spd_pkg.sv =====
`timescale 1ns / 1ps

package spd_pkg;

  // framer phase codes
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;
  localparam logic [1:0] PH_ERROR  = 2'd3;

  // header size in bytes
  localparam logic [31:0] HDR_BYTES = 32'd16;

  // command codes of the input channel
  localparam logic FUNC_DATA  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef logic [1:0] phase_t;

  // one result item
  typedef struct packed {
    logic        accepted;
    logic [7:0]  byte_out;
    logic [31:0] byte_offset;
    phase_t      phase;
    logic        header_done;
    logic        header_error;
    logic        pdu_done;
    logic [31:0] pdu_length;
    logic [31:0] command_code;
    logic [31:0] status_code;
    logic [31:0] sequence_no;
    logic        chunk_end;
  } result_t;

endpackage

// ===== design/spd_if.sv =====
`timescale 1ns / 1ps

// byte input channel
interface spd_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;
  logic       end_of_chunk;

  modport source (output valid, output func, output data_byte, output end_of_chunk,
                  input ready);
  modport sink   (input valid, input func, input data_byte, input end_of_chunk,
                  output ready);
endinterface

// framing result channel
interface spd_out_if;
  logic            valid;
  logic            ready;
  logic            accepted;
  logic [7:0]      byte_out;
  logic [31:0]     byte_offset;
  spd_pkg::phase_t phase;
  logic            header_done;
  logic            header_error;
  logic            pdu_done;
  logic [31:0]     pdu_length;
  logic [31:0]     command_code;
  logic [31:0]     status_code;
  logic [31:0]     sequence_no;
  logic            chunk_end;

  modport source (output valid, output accepted, output byte_out, output byte_offset,
                  output phase, output header_done, output header_error,
                  output pdu_done, output pdu_length, output command_code,
                  output status_code, output sequence_no, output chunk_end,
                  input ready);
  modport sink   (input valid, input accepted, input byte_out, input byte_offset,
                  input phase, input header_done, input header_error,
                  input pdu_done, input pdu_length, input command_code,
                  input status_code, input sequence_no, input chunk_end,
                  output ready);
endinterface

// ===== design/smpp_pdu_deframer.sv =====
`timescale 1ns / 1ps

// channel  | dir | contents
// ---------+-----+----------------------------------------------------------
// in_i     | in  | func, data_byte, end_of_chunk (valid/ready)
// out_o    | out | accepted, byte_out, byte_offset, phase, flags, header, chunk_end
//
// One byte per cycle while in_i.ready is high: every transaction updates the framing
// state in the cycle it is accepted, and its result is registered for out_o.
// The result side has an output register plus one skid register, so in_i.ready
// is a register and drops only when both hold results not yet taken.
// rst_ni clears the framer to waiting for a header with all header fields zero.

module smpp_pdu_deframer (
  input  logic          clk_i,
  input  logic          rst_ni,
  spd_in_if.sink        in_i,
  spd_out_if.source     out_o
);

  // framing state
  spd_pkg::phase_t phase_q, phase_d;
  logic [31:0]     count_q, count_d;
  logic [31:0]     len_q, len_d;
  logic [31:0]     cmd_q, cmd_d;
  logic [31:0]     stat_q, stat_d;
  logic [31:0]     seq_q, seq_d;

  // result buffering
  logic             out_valid_q, skid_valid_q;
  spd_pkg::result_t out_q, skid_q;
  spd_pkg::result_t res;

  logic        push, pop;
  logic [31:0] count_inc;

  assign push      = in_i.valid & in_i.ready;
  assign pop       = out_valid_q & out_o.ready;
  assign in_i.ready = ~skid_valid_q;
  assign count_inc = count_q + 32'd1;

  // next framing state and result for the incoming byte
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    len_d   = len_q;
    cmd_d   = cmd_q;
    stat_d  = stat_q;
    seq_d   = seq_q;

    res              = '0;
    res.chunk_end    = in_i.end_of_chunk;

    if (in_i.func == spd_pkg::FUNC_CLEAR) begin
      phase_d = spd_pkg::PH_HEADER;
      count_d = '0;
      len_d   = '0;
      cmd_d   = '0;
      stat_d  = '0;
      seq_d   = '0;
    end else if (phase_q == spd_pkg::PH_HEADER) begin
      res.accepted    = 1'b1;
      res.byte_out    = in_i.data_byte;
      res.byte_offset = count_q;
      // shift the byte into the field selected by its header position
      unique case (count_q[3:2])
        2'd0:    len_d  = {len_q[23:0], in_i.data_byte};
        2'd1:    cmd_d  = {cmd_q[23:0], in_i.data_byte};
        2'd2:    stat_d = {stat_q[23:0], in_i.data_byte};
        default: seq_d  = {seq_q[23:0], in_i.data_byte};
      endcase
      count_d = count_inc;
      // last header byte: check the length field
      if (count_q[3:0] == 4'hf) begin
        if (len_q < spd_pkg::HDR_BYTES) begin
          phase_d          = spd_pkg::PH_ERROR;
          res.header_error = 1'b1;
        end else begin
          res.header_done = 1'b1;
          if (len_q == spd_pkg::HDR_BYTES) begin
            phase_d      = spd_pkg::PH_DONE;
            res.pdu_done = 1'b1;
          end else begin
            phase_d = spd_pkg::PH_BODY;
          end
        end
      end
    end else if (phase_q == spd_pkg::PH_BODY) begin
      res.accepted    = 1'b1;
      res.byte_out    = in_i.data_byte;
      res.byte_offset = count_q;
      count_d         = count_inc;
      if (count_inc >= len_q) begin
        phase_d      = spd_pkg::PH_DONE;
        res.pdu_done = 1'b1;
      end
    end

    res.phase        = phase_d;
    res.pdu_length   = len_d;
    res.command_code = cmd_d;
    res.status_code  = stat_d;
    res.sequence_no  = seq_d;
  end

  // framing state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= spd_pkg::PH_HEADER;
      count_q <= '0;
      len_q   <= '0;
      cmd_q   <= '0;
      stat_q  <= '0;
      seq_q   <= '0;
    end else if (push) begin
      phase_q <= phase_d;
      count_q <= count_d;
      len_q   <= len_d;
      cmd_q   <= cmd_d;
      stat_q  <= stat_d;
      seq_q   <= seq_d;
    end
  end

  // output register and skid valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload registers
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  // result port
  assign out_o.valid        = out_valid_q;
  assign out_o.accepted     = out_q.accepted;
  assign out_o.byte_out     = out_q.byte_out;
  assign out_o.byte_offset  = out_q.byte_offset;
  assign out_o.phase        = out_q.phase;
  assign out_o.header_done  = out_q.header_done;
  assign out_o.header_error = out_q.header_error;
  assign out_o.pdu_done     = out_q.pdu_done;
  assign out_o.pdu_length   = out_q.pdu_length;
  assign out_o.command_code = out_q.command_code;
  assign out_o.status_code  = out_q.status_code;
  assign out_o.sequence_no  = out_q.sequence_no;
  assign out_o.chunk_end    = out_q.chunk_end;

endmodule
